// ----- design/auds_pkg.sv -----
// ----------------------------------------------------------------------------
// auds_pkg
// Types and constants shared by the adaptive up/down staircase block.
// ----------------------------------------------------------------------------
package auds_pkg;

   localparam int DATA_BITS     = 16;
   localparam int RUN_BITS      = 4;
   localparam int REV_BITS      = 8;
   localparam int HEAD_BITS     = 2;
   localparam int CSR_ADDR_BITS = 3;

   localparam logic REQ_START    = 1'b0;
   localparam logic REQ_RESPONSE = 1'b1;

   localparam logic ANSWER_WRONG = 1'b0;

   localparam logic [HEAD_BITS-1:0] HEAD_NONE = 2'd0;
   localparam logic [HEAD_BITS-1:0] HEAD_UP   = 2'd1;
   localparam logic [HEAD_BITS-1:0] HEAD_DOWN = 2'd2;

   localparam logic [REV_BITS-1:0]  REV_MAX   = 8'hFF;
   localparam logic [DATA_BITS-1:0] TRIAL_MAX = 16'hFFFF;

   // register indexes
   localparam logic [CSR_ADDR_BITS-1:0] CSR_LEVEL_FLOOR    = 3'd0;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_LEVEL_CEILING  = 3'd1;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_STEP_FLOOR     = 3'd2;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_WRONG_NEEDED   = 3'd3;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_RIGHT_NEEDED   = 3'd4;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_LIMIT_HITS     = 3'd5;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_REVERSAL_GOAL  = 3'd6;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_TRIAL_GOAL     = 3'd7;

   typedef struct packed {
      logic [DATA_BITS-1:0] step_floor;
      logic [RUN_BITS-1:0]  wrong_needed;
      logic [RUN_BITS-1:0]  right_needed;
      logic [RUN_BITS-1:0]  limit_hits_allowed;
      logic [REV_BITS-1:0]  reversal_goal;
      logic [DATA_BITS-1:0] trial_goal;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      step_floor:         16'd1,
      wrong_needed:       4'd1,
      right_needed:       4'd2,
      limit_hits_allowed: 4'd2,
      reversal_goal:      8'd50,
      trial_goal:         16'd150
   };

   typedef struct packed {
      logic [DATA_BITS-1:0] step;
      logic [RUN_BITS-1:0]  wrong_run;
      logic [RUN_BITS-1:0]  right_run;
      logic [HEAD_BITS-1:0] heading;
      logic [REV_BITS-1:0]  reversals;
      logic [RUN_BITS-1:0]  bound_hits;
      logic [DATA_BITS-1:0] trials;
   } stair_type;

endpackage

// ----- design/auds_update.sv -----
// ----------------------------------------------------------------------------
// auds_update
// Next-state logic of the staircase: start load or one response update.
// ----------------------------------------------------------------------------
module auds_update #(
   parameter int LEVEL_BITS = 16,
   localparam int LvlW = (LEVEL_BITS < auds_pkg::DATA_BITS) ? LEVEL_BITS : auds_pkg::DATA_BITS
) (
   input  logic                           req_type,
   input  logic [auds_pkg::DATA_BITS-1:0] start_level,
   input  logic [auds_pkg::DATA_BITS-1:0] start_step,
   input  logic                           answer_right,
   input  auds_pkg::cfg_type              cfg,
   input  logic [LvlW-1:0]                level_floor,
   input  logic [LvlW-1:0]                level_ceiling,
   input  auds_pkg::stair_type            state_cur,
   input  logic [LvlW-1:0]                level_cur,
   output auds_pkg::stair_type            state_nxt,
   output logic [LvlW-1:0]                level_nxt,
   output logic                           done
);

   localparam int DW   = auds_pkg::DATA_BITS;

   always_comb begin
      auds_pkg::stair_type  st;
      logic [LvlW-1:0]      lvl;
      logic                 move_up;
      logic                 move_dn;
      logic                 turn;
      logic [DW-1:0]        half;
      logic [DW:0]          sum;
      logic [DW:0]          diff;
      logic [DW-1:0]        lvl_ext;
      logic [DW-1:0]        floor_ext;
      logic                 clamp;
      logic [auds_pkg::RUN_BITS-1:0] hits;

      st        = state_cur;
      lvl       = level_cur;
      move_up   = 1'b0;
      move_dn   = 1'b0;
      turn      = 1'b0;
      half      = '0;
      sum       = '0;
      diff      = '0;
      lvl_ext   = '0;
      floor_ext = DW'(level_floor);
      clamp     = 1'b0;
      hits      = '0;

      if (req_type == auds_pkg::REQ_START) begin
         lvl = start_level[LvlW-1:0];
         if (lvl < level_floor) begin
            lvl = level_floor;
         end else if (lvl > level_ceiling) begin
            lvl = level_ceiling;
         end
         st.step       = start_step;
         st.wrong_run  = '0;
         st.right_run  = '0;
         st.heading    = auds_pkg::HEAD_NONE;
         st.reversals  = '0;
         st.bound_hits = '0;
         st.trials     = '0;
      end else begin
         if (st.trials != auds_pkg::TRIAL_MAX) begin
            st.trials = st.trials + 1'b1;
         end
         if (answer_right == auds_pkg::ANSWER_WRONG) begin
            st.wrong_run = st.wrong_run + 1'b1;
            st.right_run = '0;
            if (st.wrong_run == cfg.wrong_needed) begin
               move_up      = 1'b1;
               st.wrong_run = '0;
            end
         end else begin
            st.right_run = st.right_run + 1'b1;
            st.wrong_run = '0;
            if (st.right_run == cfg.right_needed) begin
               move_dn      = 1'b1;
               st.right_run = '0;
            end
         end

         if (move_up || move_dn) begin
            turn = move_up ? (st.heading == auds_pkg::HEAD_DOWN)
                           : (st.heading == auds_pkg::HEAD_UP);
            if (turn) begin
               if (st.reversals != auds_pkg::REV_MAX) begin
                  st.reversals = st.reversals + 1'b1;
               end
               half    = st.step >> 1;
               st.step = (half < cfg.step_floor) ? cfg.step_floor : half;
            end
            st.heading = move_up ? auds_pkg::HEAD_UP : auds_pkg::HEAD_DOWN;

            lvl_ext = DW'(lvl);
            if (move_up) begin
               sum   = {1'b0, lvl_ext} + {1'b0, st.step};
               clamp = sum > {1'b0, DW'(level_ceiling)};
               lvl   = clamp ? level_ceiling : sum[LvlW-1:0];
            end else begin
               diff  = {1'b0, lvl_ext} - {1'b0, st.step};
               clamp = diff[DW] || (diff[DW-1:0] < floor_ext);
               lvl   = clamp ? level_floor : diff[LvlW-1:0];
            end

            // limit_hits_allowed clamped moves in a row count as one reversal
            if (clamp) begin
               hits = st.bound_hits + 1'b1;
               if (hits >= cfg.limit_hits_allowed) begin
                  if (st.reversals != auds_pkg::REV_MAX) begin
                     st.reversals = st.reversals + 1'b1;
                  end
                  st.bound_hits = '0;
               end else begin
                  st.bound_hits = hits;
               end
            end else begin
               st.bound_hits = '0;
            end
         end
      end

      state_nxt = st;
      level_nxt = lvl;
      done      = (st.reversals >= cfg.reversal_goal) || (st.trials >= cfg.trial_goal);
   end

endmodule

// ----- design/adaptive_up_down_staircase_top.sv -----
// ----------------------------------------------------------------------------
// adaptive_up_down_staircase_top
// N-up/M-down adaptive staircase on an unsigned fixed-point stimulus level.
//
//  channel | dir | width   | contents (lowest bit up)
//  req     | in  | 40 + 1  | tdata: start_level, start_step, answer_right; tuser: req_type
//  rsp     | out | 64      | tdata: level, step_now, reversals, trials, done_res
//  csr     | in  | 3 + 16  | index, write data
//
// One transaction per cycle sustained while rsp_tready stays high; each request passes
// through the input register, then the update into the result register. Reset clears
// the valid flags, state and counters and loads the default configuration.
// A stalled result holds the update stage; the input register keeps accepting
// until it is full.
// ----------------------------------------------------------------------------
module adaptive_up_down_staircase_top #(
   parameter int LEVEL_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // start_level[15:0], start_step[31:16], answer_right[32]
   input  logic        req_tuser,   // req_type[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // level[15:0], step_now[31:16], reversals[39:32],
                                    // trials[55:40], done_res[56]
   input  logic        csr_we,
   input  logic [auds_pkg::CSR_ADDR_BITS-1:0] csr_addr,
   input  logic [auds_pkg::DATA_BITS-1:0]     csr_wdata
);

   localparam int LvlW = (LEVEL_BITS < auds_pkg::DATA_BITS) ? LEVEL_BITS : auds_pkg::DATA_BITS;
   localparam int DW   = auds_pkg::DATA_BITS;

   logic                 in_valid_ff;
   logic                 in_type_ff;
   logic [DW-1:0]        in_level_ff;
   logic [DW-1:0]        in_step_ff;
   logic                 in_answer_ff;

   auds_pkg::cfg_type    cfg_ff;
   logic [LvlW-1:0]      floor_ff;
   logic [LvlW-1:0]      ceiling_ff;

   auds_pkg::stair_type  state_ff;
   auds_pkg::stair_type  state_in;
   logic [LvlW-1:0]      level_ff;
   logic [LvlW-1:0]      level_in;
   logic                 done_in;

   logic                 out_valid_ff;
   logic [63:0]          out_data_ff;
   logic [63:0]          out_data_in;

   logic                 out_free;
   logic                 advance;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_type_ff   <= req_tuser;
         in_level_ff  <= req_tdata[15:0];
         in_step_ff   <= req_tdata[31:16];
         in_answer_ff <= req_tdata[32];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff     <= auds_pkg::CFG_RESET;
         floor_ff   <= '0;
         ceiling_ff <= '1;
      end else if (csr_we) begin
         case (csr_addr)
            auds_pkg::CSR_LEVEL_FLOOR:   floor_ff   <= csr_wdata[LvlW-1:0];
            auds_pkg::CSR_LEVEL_CEILING: ceiling_ff <= csr_wdata[LvlW-1:0];
            auds_pkg::CSR_STEP_FLOOR:    cfg_ff.step_floor <= csr_wdata;
            auds_pkg::CSR_WRONG_NEEDED:  cfg_ff.wrong_needed <= csr_wdata[3:0];
            auds_pkg::CSR_RIGHT_NEEDED:  cfg_ff.right_needed <= csr_wdata[3:0];
            auds_pkg::CSR_LIMIT_HITS:    cfg_ff.limit_hits_allowed <= csr_wdata[3:0];
            auds_pkg::CSR_REVERSAL_GOAL: cfg_ff.reversal_goal <= csr_wdata[7:0];
            auds_pkg::CSR_TRIAL_GOAL:    cfg_ff.trial_goal <= csr_wdata;
            default: ;
         endcase
      end
   end

   auds_update #(
      .LEVEL_BITS (LEVEL_BITS)
   ) u_update (
      .req_type      (in_type_ff),
      .start_level   (in_level_ff),
      .start_step    (in_step_ff),
      .answer_right  (in_answer_ff),
      .cfg           (cfg_ff),
      .level_floor   (floor_ff),
      .level_ceiling (ceiling_ff),
      .state_cur     (state_ff),
      .level_cur     (level_ff),
      .state_nxt     (state_in),
      .level_nxt     (level_in),
      .done          (done_in)
   );

   assign out_data_in = {7'd0, done_in, state_in.trials, state_in.reversals,
                         state_in.step, DW'(level_in)};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
         level_ff <= '0;
      end else if (advance) begin
         state_ff <= state_in;
         level_ff <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

endmodule
